@@ src/nth_substring_match_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the n-th substring match block
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef NTH_SUBSTRING_MATCH_ASSERT_SVH
`define NTH_SUBSTRING_MATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSM_ASSERT_IMPLY(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nth_substring_match: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define NSM_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nth_substring_match: property violated");

`endif

@@ src/nsm_pkg.sv @@
// ---------------------------------------------------------------------------
// n-th substring match package
// Widths, codes and control structures shared by the block's files.
// ---------------------------------------------------------------------------
package nsm_pkg;

	// Default sizing of the block.
	localparam int DEF_MAX_PATTERN = 64;
	localparam int DEF_OFFSET_BITS = 16;

	// Fixed field widths.
	localparam int BYTE_W       = 8;
	localparam int TARGET_W     = 16;
	localparam int COUNT_W      = 16;
	localparam int OFFSET_OUT_W = 16;
	localparam int STATUS_W     = 2;

	// Command codes.
	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

	// Per-transaction controls broadcast along the cell row.
	typedef struct packed {
		logic shift;
		logic clear;
		logic load;
	} cell_ctrl_t;

	// Flags of an item held between the cell row and the tally stage.
	typedef struct packed {
		logic text;
		logic last;
		logic over;
		logic hit;
		logic empty;
		logic first;
	} nsm_flags_t;

endpackage

@@ src/nsm_channels.sv @@
// ---------------------------------------------------------------------------
// n-th substring match channels
// Valid/ready interfaces for the item, result and configuration channels.
// ---------------------------------------------------------------------------

// Input items: pattern or text bytes.
interface nsm_item_if;
	import nsm_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [BYTE_W-1:0] data_byte;
	logic              last;

	modport source (output valid, output cmd, output data_byte, output last, input ready);
	modport sink   (input valid, input cmd, input data_byte, input last, output ready);
endinterface

// Result items: one per text line.
interface nsm_result_if;
	import nsm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [OFFSET_OUT_W-1:0] match_offset;

	modport source (output valid, output status, output match_offset, input ready);
	modport sink   (input valid, input status, input match_offset, output ready);
endinterface

// Configuration writes: the occurrence target register.
interface nsm_cfg_if;
	import nsm_pkg::*;
	logic                valid;
	logic                ready;
	logic [TARGET_W-1:0] wdata;

	modport source (output valid, output wdata, input ready);
	modport sink   (input valid, input wdata, output ready);
endinterface

@@ src/nth_substring_match.sv @@
// ---------------------------------------------------------------------------
// n-th substring match
// Reports the start offset of the n-th occurrence of a pattern in a text line.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle. Pattern bytes load a row of
// MAX_PATTERN cells, one per pattern position; each text byte is broadcast
// to every cell, and each cell passes its partial-match bit to its right-hand
// neighbour, so a whole window is compared in the single cycle in which its
// last byte arrives. A tally stage behind the row counts matches. Once the
// text byte marked last is accepted, the line result is registered in stage
// one and then in the output register. Input is held off only when a
// second line ends while the previous result has not yet been taken. There
// is no clearing pass after reset: the pattern store is written before use.
module nth_substring_match #(
	parameter int MAX_PATTERN = nsm_pkg::DEF_MAX_PATTERN,
	parameter int OFFSET_BITS = nsm_pkg::DEF_OFFSET_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	nsm_item_if.sink     item,
	nsm_result_if.source result,
	nsm_cfg_if.sink      cfg
);
	import nsm_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int CNT_W = OFFSET_BITS + 1;

	logic [LEN_W-1:0]       pat_len_q;
	logic                   restart_q;
	logic [CNT_W-1:0]       text_cnt_q;
	logic [TARGET_W-1:0]    target_q;
	logic                   accept;
	logic                   is_text;
	logic                   over;
	logic [LEN_W-1:0]       load_len;
	logic                   load_room;
	cell_ctrl_t             cell_ctrl;
	logic [MAX_PATTERN-1:0] sel;
	logic [MAX_PATTERN-1:0] m_q;
	logic [MAX_PATTERN-1:0] m_next;
	logic                   hit;
	logic                   valid_s1;
	nsm_flags_t             flags_s1;
	logic [CNT_W-1:0]       start_s1;
	logic                   consume;

	// Input handshake and decoding.
	assign item.ready = !valid_s1 || consume;
	assign accept     = item.valid && item.ready;
	assign is_text    = item.cmd == CMD_TEXT;
	assign over       = text_cnt_q[OFFSET_BITS];
	assign load_len   = restart_q ? '0 : pat_len_q;
	assign load_room  = load_len < LEN_W'(MAX_PATTERN);

	// Controls broadcast to every cell.
	assign cell_ctrl.shift = accept && is_text && !over;
	assign cell_ctrl.clear = accept && (!is_text || item.last);
	assign cell_ctrl.load  = accept && !is_text && load_room;

	// Configuration register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			target_q <= cfg.wdata;
		end
	end

	// The row of cells; the first cell always sees a matched empty prefix.
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic prev_m;

		assign sel[k] = load_len == LEN_W'(k);

		if (k == 0) begin : g_head
			assign prev_m = 1'b1;
		end else begin : g_link
			assign prev_m = m_q[k-1];
		end

		nsm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.sel       (sel[k]),
			.data_byte (item.data_byte),
			.prev_m    (prev_m),
			.m_q       (m_q[k]),
			.m_next    (m_next[k])
		);
	end

	// A full match is the partial-match bit of the cell at the pattern's end.
	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			hit = hit | (m_next[k] && (pat_len_q == LEN_W'(k + 1)));
		end
	end

	// Pattern length and restart flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			restart_q <= 1'b1;
		end else if (accept) begin
			if (!is_text) begin
				pat_len_q <= load_len + LEN_W'(load_room);
				restart_q <= item.last;
			end else begin
				restart_q <= 1'b1;
			end
		end
	end

	// Text byte counter, saturating one past the offset range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_cnt_q <= '0;
		end else if (accept) begin
			if (!is_text || item.last) begin
				text_cnt_q <= '0;
			end else if (!over) begin
				text_cnt_q <= text_cnt_q + CNT_W'(1);
			end
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload: match flags and candidate start offset.
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1.text  <= is_text;
			flags_s1.last  <= item.last;
			flags_s1.over  <= over;
			flags_s1.hit   <= hit;
			flags_s1.empty <= pat_len_q == '0;
			flags_s1.first <= text_cnt_q == '0;
			if (pat_len_q == '0) begin
				start_s1 <= text_cnt_q + CNT_W'(1);
			end else begin
				start_s1 <= text_cnt_q + CNT_W'(1) - CNT_W'(pat_len_q);
			end
		end
	end

	// Match tally and result register.
	nsm_tally #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (valid_s1),
		.flags        (flags_s1),
		.start        (start_s1),
		.target       (target_q),
		.out_ready    (result.ready),
		.consume      (consume),
		.out_valid    (result.valid),
		.status       (result.status),
		.match_offset (result.match_offset)
	);

endmodule

@@ src/nsm_cell.sv @@
// ---------------------------------------------------------------------------
// n-th substring match cell
// Holds one pattern byte and the partial-match bit for that pattern position.
// ---------------------------------------------------------------------------
module nsm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  nsm_pkg::cell_ctrl_t       ctrl,
	input  logic                      sel,
	input  logic [nsm_pkg::BYTE_W-1:0] data_byte,
	input  logic                      prev_m,
	output logic                      m_q,
	output logic                      m_next
);
	import nsm_pkg::*;

	logic [BYTE_W-1:0] pat_q;

	// The prefix ending here matches if the left neighbour matched one byte ago
	// and this byte equals the stored pattern byte.
	assign m_next = prev_m && (data_byte == pat_q);

	// Pattern byte storage, written while a pattern is loaded.
	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			pat_q <= data_byte;
		end
	end

	// Partial-match bit: cleared on a pattern byte or line end, else advanced on a text byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= 1'b0;
		end else if (ctrl.clear) begin
			m_q <= 1'b0;
		end else if (ctrl.shift) begin
			m_q <= m_next;
		end
	end

endmodule

@@ src/nsm_tally.sv @@
// ---------------------------------------------------------------------------
// n-th substring match tally
// Counts matches, records the n-th start offset and issues the line result.
// ---------------------------------------------------------------------------
module nsm_tally #(
	parameter int OFFSET_BITS = nsm_pkg::DEF_OFFSET_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s1_valid,
	input  nsm_pkg::nsm_flags_t             flags,
	input  logic [OFFSET_BITS:0]            start,
	input  logic [nsm_pkg::TARGET_W-1:0]    target,
	input  logic                            out_ready,
	output logic                            consume,
	output logic                            out_valid,
	output logic [nsm_pkg::STATUS_W-1:0]    status,
	output logic [nsm_pkg::OFFSET_OUT_W-1:0] match_offset
);
	import nsm_pkg::*;

	logic [COUNT_W-1:0]     cnt_q;
	logic                   found_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic                   lost_q;
	logic [COUNT_W-1:0]     nxt_cnt;
	logic                   nxt_found;
	logic [OFFSET_BITS-1:0] nxt_off;
	logic                   nxt_lost;
	logic                   counting;
	logic                   ends_line;
	logic                   out_free;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [OFFSET_OUT_W-1:0] offset_q;

	// Handshake: an item ending a line needs the output register free.
	assign counting  = target != '0;
	assign ends_line = flags.text && flags.last;
	assign out_free  = !out_valid_q || out_ready;
	assign consume   = s1_valid && (!ends_line || out_free);

	// Apply this item's candidate matches in order: the empty-pattern match at
	// offset zero first, then a row or empty-pattern match at the start offset.
	always_comb begin
		nxt_cnt   = cnt_q;
		nxt_found = found_q;
		nxt_off   = off_q;
		nxt_lost  = lost_q;
		if (flags.over) begin
			nxt_lost = 1'b1;
		end else begin
			if (flags.empty && flags.first && !nxt_found && counting) begin
				nxt_cnt = nxt_cnt + COUNT_W'(1);
				if (nxt_cnt == target) begin
					nxt_found = 1'b1;
					nxt_off   = '0;
				end
			end
			if (flags.empty || flags.hit) begin
				if (start[OFFSET_BITS]) begin
					nxt_lost = 1'b1;
				end else if (!nxt_found && counting) begin
					nxt_cnt = nxt_cnt + COUNT_W'(1);
					if (nxt_cnt == target) begin
						nxt_found = 1'b1;
						nxt_off   = start[OFFSET_BITS-1:0];
					end
				end
			end
		end
	end

	// Line state: cleared by a pattern byte and after each line result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			off_q   <= '0;
			lost_q  <= 1'b0;
		end else if (consume) begin
			if (!flags.text || flags.last) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				off_q   <= '0;
				lost_q  <= 1'b0;
			end else begin
				cnt_q   <= nxt_cnt;
				found_q <= nxt_found;
				off_q   <= nxt_off;
				lost_q  <= nxt_lost;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && ends_line) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (consume && ends_line) begin
			if (nxt_found) begin
				status_q <= ST_FOUND;
				offset_q <= OFFSET_OUT_W'(nxt_off);
			end else begin
				status_q <= nxt_lost ? ST_TOO_LONG : ST_NOT_FOUND;
				offset_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign match_offset = offset_q;

endmodule

@@ src/nsm_checker.sv @@
// ---------------------------------------------------------------------------
// n-th substring match checker
// Port-level properties of the block, bound to the top level.
// ---------------------------------------------------------------------------
`include "nth_substring_match_assert.svh"

module nsm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_ready,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic [nsm_pkg::STATUS_W-1:0]     status,
	input logic [nsm_pkg::OFFSET_OUT_W-1:0] match_offset
);
	import nsm_pkg::*;

	logic                                 res_stall;
	logic [STATUS_W+OFFSET_OUT_W-1:0]     res_data;
	logic                                 status_ok;
	logic                                 is_miss;

	// Helper terms that keep the properties short.
	assign res_stall = result_valid && !result_ready;
	assign res_data  = {status, match_offset};
	assign status_ok = status == ST_FOUND || status == ST_NOT_FOUND || status == ST_TOO_LONG;
	assign is_miss   = status != ST_FOUND;

	// A stalled result holds its payload.
	`NSM_ASSERT_NEXT(a_result_hold, clk, arst_n, res_stall, result_valid && $stable(res_data))

	// Only the three defined status codes are issued.
	`NSM_ASSERT_IMPLY(a_status_code, clk, arst_n, result_valid, status_ok)

	// A result that is not a find carries a zero offset.
	`NSM_ASSERT_IMPLY(a_offset_zero, clk, arst_n, result_valid && is_miss, match_offset == '0)

	// Input is held off only while a result waits to be taken.
	`NSM_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !item_ready, res_stall)

endmodule

bind nth_substring_match nsm_checker u_nsm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.status       (result.status),
	.match_offset (result.match_offset)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the n-th substring match block
// Streams pattern and text bytes into the block and predicts every line result
// with a behavioural copy of the matcher. Each result transaction is checked
// field by field against the oldest pending prediction. Directed tests cover
// the empty pattern, overlapping matches, byte extremes, and over-long and
// interrupted patterns. Random traffic then runs under four mixes of sender
// idling and receiver stalling.
// ---------------------------------------------------------------------------
module tb_top;
	import nsm_pkg::*;

	localparam int MAX_PAT       = DEF_MAX_PATTERN;
	localparam int OFF_LIMIT     = 1 << DEF_OFFSET_BITS;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [OFFSET_OUT_W-1:0] offset;
	} line_result_t;

	logic clk;
	logic arst_n;

	nsm_item_if   item_ch ();
	nsm_result_if result_ch ();
	nsm_cfg_if    cfg_ch ();

	nth_substring_match dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: the loaded pattern, the running line and the target.
	logic [BYTE_W-1:0]   pat_mem [MAX_PAT];
	logic [6:0]          pat_len;
	bit                  pat_fresh;
	logic [BYTE_W-1:0]   text_ring [MAX_PAT];
	logic [16:0]         text_pos;
	logic [COUNT_W-1:0]  hit_tally;
	bit                  nth_seen;
	logic [15:0]         nth_start;
	bit                  beyond_range;
	logic [TARGET_W-1:0] occ_target;

	line_result_t line_results_due [$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int items_sent         = 0;
	int lines_checked      = 0;
	int targets_written    = 0;
	int error_count        = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Overall time limit for the run.
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Line result predictor
	// ------------------------------------------------------------------

	// Clears everything that belongs to the current text line.
	function automatic void reset_line_state();
		for (int i = 0; i < MAX_PAT; i++)
			text_ring[i] = '0;
		text_pos     = '0;
		hit_tally    = '0;
		nth_seen     = 1'b0;
		nth_start    = '0;
		beyond_range = 1'b0;
	endfunction

	// Counts one match starting at the given offset.
	function automatic void tally_hit(input int start);
		if (start > OFF_LIMIT - 1) begin
			beyond_range = 1'b1;
			return;
		end
		if (nth_seen || occ_target == '0)
			return;
		hit_tally = hit_tally + 1'b1;
		if (hit_tally == occ_target) begin
			nth_seen  = 1'b1;
			nth_start = 16'(start);
		end
	endfunction

	// Compares the window ending at text index t with the pattern.
	function automatic bit window_equal(input int t);
		int first;
		first = t + 1 - int'(pat_len);
		for (int k = 0; k < int'(pat_len); k++)
			if (text_ring[(first + k) % MAX_PAT] != pat_mem[k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Takes one text byte into the line.
	function automatic void absorb_text(input logic [BYTE_W-1:0] b);
		int t;
		t = int'(text_pos);
		if (t >= OFF_LIMIT) begin
			beyond_range = 1'b1;
			return;
		end
		text_ring[t % MAX_PAT] = b;
		if (pat_len == '0) begin
			// The empty pattern matches at every offset, the end included.
			if (t == 0)
				tally_hit(0);
			tally_hit(t + 1);
		end else if (t + 1 >= int'(pat_len) && window_equal(t)) begin
			tally_hit(t + 1 - int'(pat_len));
		end
		text_pos = 17'(t + 1);
	endfunction

	// Updates the predictor for one accepted item and queues any line result.
	function automatic void predict_item(input logic cmd, input logic [BYTE_W-1:0] b,
			input logic last);
		line_result_t res;
		if (cmd == CMD_PATTERN) begin
			if (pat_fresh) begin
				pat_len   = '0;
				pat_fresh = 1'b0;
			end
			// Bytes beyond the pattern store are dropped.
			if (int'(pat_len) < MAX_PAT) begin
				pat_mem[pat_len] = b;
				pat_len          = pat_len + 1'b1;
			end
			if (last)
				pat_fresh = 1'b1;
			reset_line_state();
			return;
		end
		pat_fresh = 1'b1;
		absorb_text(b);
		if (!last)
			return;
		if (nth_seen) begin
			res.status = ST_FOUND;
			res.offset = nth_start;
		end else begin
			res.status = beyond_range ? ST_TOO_LONG : ST_NOT_FOUND;
			res.offset = '0;
		end
		line_results_due.push_back(res);
		reset_line_state();
	endfunction

	// ------------------------------------------------------------------
	// Driving and checking
	// ------------------------------------------------------------------

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Compares one result transaction with the oldest pending prediction.
	task automatic check_result(input logic [STATUS_W-1:0] status,
			input logic [OFFSET_OUT_W-1:0] offset);
		line_result_t want;
		if (line_results_due.size() == 0) begin
			report_mismatch($sformatf("result status %0d offset %0d with none pending",
				status, offset));
			return;
		end
		want = line_results_due.pop_front();
		lines_checked++;
		if (status !== want.status)
			report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
		if (offset !== want.offset)
			report_mismatch($sformatf("match_offset %0d, predicted %0d", offset,
				want.offset));
	endtask

	// Result receiver: checks each transaction and stalls at random.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
				check_result(result_ch.status, result_ch.match_offset);
			result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Sends one item and updates the predictor once it has been accepted.
	task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.cmd       <= cmd;
		item_ch.data_byte <= b;
		item_ch.last      <= last;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predict_item(cmd, b, last);
		items_sent++;
	endtask

	// Holds the item channel idle until every predicted result has arrived.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (line_results_due.size() != 0)
			@(posedge clk);
		// Pattern items leave nothing to wait for, so let the pipeline empty.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the occurrence target while the block is idle.
	task automatic write_target(input logic [TARGET_W-1:0] value);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.wdata <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		occ_target = value;
		targets_written++;
	endtask

	task automatic load_pattern(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(CMD_PATTERN, s[i], i == s.len() - 1);
	endtask

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_item(CMD_TEXT, s[i], close && i == s.len() - 1);
	endtask

	// Mostly one of two symbols, so that short patterns match often.
	function automatic logic [BYTE_W-1:0] alphabet_byte(input logic [BYTE_W-1:0] sa,
			input logic [BYTE_W-1:0] sb);
		if ($urandom_range(9) == 0)
			return 8'($urandom);
		return $urandom_range(1) ? sa : sb;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// No pattern has been loaded yet, so every offset matches.
	task automatic test_empty_pattern();
		send_text("abc", 1'b1);
		write_target(16'd3);
		send_text("xy", 1'b1);
		send_text("q", 1'b1);
		write_target(16'd0);
		send_text("hello", 1'b1);
	endtask

	// Plain, later and overlapping occurrences, and the byte extremes.
	task automatic test_directed_matches();
		write_target(16'd1);
		load_pattern("ab");
		send_text("xabab", 1'b1);
		write_target(16'd2);
		send_text("xabab", 1'b1);
		load_pattern("aa");
		write_target(16'd3);
		send_text("aaaa", 1'b1);
		write_target(16'd1);
		send_text("a", 1'b1);
		send_item(CMD_PATTERN, 8'h00, 1'b0);
		send_item(CMD_PATTERN, 8'hFF, 1'b1);
		send_item(CMD_TEXT, 8'hFF, 1'b0);
		send_item(CMD_TEXT, 8'h00, 1'b0);
		send_item(CMD_TEXT, 8'hFF, 1'b1);
		write_target(16'hFFFF);
		send_item(CMD_TEXT, 8'h00, 1'b0);
		send_item(CMD_TEXT, 8'hFF, 1'b1);
		write_target(16'd1);
	endtask

	// Patterns cut by text, text cut by patterns, and an over-long pattern.
	task automatic test_broken_sequences();
		logic [BYTE_W-1:0] long_pat [70];
		load_pattern("ab");
		send_text("ab", 1'b0);
		send_item(CMD_PATTERN, "c", 1'b1);
		send_text("xc", 1'b1);
		send_item(CMD_PATTERN, "p", 1'b0);
		send_item(CMD_PATTERN, "q", 1'b0);
		send_text("zpq", 1'b1);
		send_item(CMD_PATTERN, "r", 1'b1);
		send_text("rr", 1'b1);
		for (int i = 0; i < 70; i++) begin
			long_pat[i] = 8'($urandom);
			send_item(CMD_PATTERN, long_pat[i], i == 69);
		end
		for (int i = 0; i < MAX_PAT; i++)
			send_item(CMD_TEXT, long_pat[i], i == MAX_PAT - 1);
	endtask

	// Random lines, mostly well formed, with noise and interrupted sequences.
	task automatic run_random_lines(input int n_items);
		int first_item;
		int r;
		int plen;
		int tlen;
		bit cut;
		logic [BYTE_W-1:0] sa;
		logic [BYTE_W-1:0] sb;
		first_item = items_sent;
		sa = 8'($urandom);
		sb = 8'($urandom);
		write_target(16'($urandom_range(1, 3)));
		while (items_sent - first_item < n_items) begin
			r = $urandom_range(99);
			if (r < 10) begin
				// Noise: any command, byte and last flag.
				send_item(1'($urandom), 8'($urandom), 1'($urandom));
			end else begin
				plen = 0;
				if (r < 40) begin
					sa   = 8'($urandom);
					sb   = 8'($urandom);
					plen = ($urandom_range(19) == 0) ? $urandom_range(60, 68)
						: $urandom_range(1, 4);
					// A few loads are left open and ended by the text.
					for (int i = 0; i < plen; i++)
						send_item(CMD_PATTERN, alphabet_byte(sa, sb),
							(r < 35) && (i == plen - 1));
				end
				tlen = (plen > 8) ? $urandom_range(plen - 4, plen + 8) : $urandom_range(1, 24);
				cut  = (r >= 92);
				for (int i = 0; i < tlen; i++)
					send_item(CMD_TEXT, alphabet_byte(sa, sb), !cut && (i == tlen - 1));
				if (cut)
					send_item(CMD_PATTERN, alphabet_byte(sa, sb), 1'($urandom));
			end
			if ($urandom_range(19) == 0)
				drain_results();
			if ($urandom_range(29) == 0)
				write_target(16'($urandom_range(1, 4)));
		end
	endtask

	task automatic test_random_traffic();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		run_random_lines(125);
		sender_idle_pct    = 81;
		receiver_stall_pct = 0;
		run_random_lines(125);
		sender_idle_pct    = 0;
		receiver_stall_pct = 81;
		run_random_lines(125);
		sender_idle_pct    = 18;
		receiver_stall_pct = 18;
		run_random_lines(125);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.cmd       <= CMD_PATTERN;
		item_ch.data_byte <= '0;
		item_ch.last      <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.wdata      <= '0;
		for (int i = 0; i < MAX_PAT; i++)
			pat_mem[i] = '0;
		pat_len    = '0;
		pat_fresh  = 1'b1;
		occ_target = 16'd1;
		reset_line_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pattern();
		test_directed_matches();
		test_broken_sequences();
		test_random_traffic();
		drain_results();

		$display("Checked %0d line results from %0d items with %0d target writes.",
			lines_checked, items_sent, targets_written);
		$display("Covered empty, overlapping, over-long and cut patterns, target changes"
			, " and four idle mixes.");
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
